@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tone oscillator
// Clocked concurrent checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define TOS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define TOS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/tos_pkg.sv @@
// ----------------------------------------------------------------------------
// tos_pkg
// Shared constants, register codes and types of the tone oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package tos_pkg;

  localparam int MaxChannelsDef   = 8;
  localparam int SineTableBitsDef = 10;
  localparam int PhaseBitsDef     = 32;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 32;

  localparam int VolumeW    = 16;
  localparam int PhaseStepW = 32;
  localparam int ChanCfgW   = 4;
  localparam int SampleW    = 16;
  localparam int RomDataW   = 15;
  localparam int ValueW     = 16;
  localparam int ProdW      = VolumeW + ValueW;
  localparam int FracBits   = 15;
  localparam int MagW       = ProdW - FracBits;

  localparam logic [VolumeW-1:0]    VolumeRst    = 16'h8000;
  localparam logic [PhaseStepW-1:0] PhaseStepRst = 32'd39370534;
  localparam logic [ChanCfgW-1:0]   ChanCfgRst   = 4'd2;

  localparam logic [ValueW-1:0] SquareValue = 16'h8000;
  localparam logic [ProdW:0]    RoundHalf   = 33'd16384;
  localparam logic [MagW-1:0]   PosLimit    = 17'd32767;
  localparam logic [MagW-1:0]   NegLimit    = 17'd32768;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_WAVE_SHAPE    = 4'd0,
    CFG_VOLUME        = 4'd1,
    CFG_PHASE_STEP    = 4'd2,
    CFG_CHANNEL_COUNT = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic             negative;
  } frame_t;

endpackage

`default_nettype wire

@@ design/tos_sine_rom.sv @@
// ----------------------------------------------------------------------------
// tos_sine_rom
// Quarter-wave sine table with a registered read port, built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_sine_rom #(
  parameter int TableBits = tos_pkg::SineTableBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [TableBits-1:0]          addr_i,
  output logic      [tos_pkg::RomDataW-1:0]  data_o
);
  import tos_pkg::*;

  localparam int TableLen = 2 ** TableBits;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic [RomDataW-1:0] rom_t [TableLen];

  function automatic logic [RomDataW-1:0] quarter_sine(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] res;
    x    = (HalfPiQ30 * (64'(k) * 64'd2 + 64'd1)) >> (TableBits + 1);
    x2   = (x * x) >> 30;
    acc  = x;
    term = ((x * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - term;
    res  = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return res[RomDataW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TableLen; k++) begin
      r[k] = quarter_sine(k);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [RomDataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= SineRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/tos_phase_acc.sv @@
// ----------------------------------------------------------------------------
// tos_phase_acc
// Phase accumulator; derives the table address and sign from the phase.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tos_phase_acc #(
  parameter int PhaseBits = tos_pkg::PhaseBitsDef,
  parameter int TableBits = tos_pkg::SineTableBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            advance_i,
  input  wire logic [tos_pkg::PhaseStepW-1:0]  phase_step_i,
  output logic      [TableBits-1:0]            rom_addr_o,
  output logic                                 negative_o
);
  import tos_pkg::*;

  logic [PhaseBits-1:0] phase_q, phase_d;
  logic [PhaseBits-1:0] step_ext;
  logic [TableBits-1:0] idx;

  assign step_ext = PhaseBits'(phase_step_i);
  assign phase_d  = phase_q + step_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
    end
  end

  // mirror the index in odd quadrants, negate in the upper half of the phase
  assign idx        = phase_q[PhaseBits-3 -: TableBits];
  assign rom_addr_o = phase_q[PhaseBits-2] ? ~idx : idx;
  assign negative_o = phase_q[PhaseBits-1];

  `TOS_ASSERT(a_phase_adv, clk_i, rst_ni,
    advance_i |=> phase_q == $past(phase_q) + $past(step_ext), "phase did not advance")
  `TOS_ASSERT(a_phase_hold, clk_i, rst_ni,
    !advance_i |=> $stable(phase_q), "phase moved without a frame")

endmodule

`default_nettype wire

@@ design/tos_frame_out.sv @@
// ----------------------------------------------------------------------------
// tos_frame_out
// Rounds and saturates one frame sample and repeats it once per channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tos_frame_out #(
  parameter int MaxChannels = tos_pkg::MaxChannelsDef,
  localparam int CntW       = $clog2(MaxChannels + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire tos_pkg::frame_t               frame_i,
  input  wire logic [CntW-1:0]               chans_i,
  output logic                               can_load_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic signed [tos_pkg::SampleW-1:0] sample_o,
  output logic                               last_channel_o
);
  import tos_pkg::*;

  logic                out_valid_q;
  logic [CntW-1:0]     left_q;
  logic [SampleW-1:0]  sample_q, sample_d;
  logic [ProdW:0]      rnd;
  logic [MagW-1:0]     mag, lim;
  logic                is_last, take;

  assign rnd = {1'b0, frame_i.prod} + RoundHalf;
  assign mag = rnd[ProdW-1:FracBits];

  always_comb begin
    if (frame_i.negative) begin
      lim      = (mag > NegLimit) ? NegLimit : mag;
      sample_d = SampleW'(0) - lim[SampleW-1:0];
    end else begin
      lim      = (mag > PosLimit) ? PosLimit : mag;
      sample_d = lim[SampleW-1:0];
    end
  end

  assign is_last    = (left_q == CntW'(1));
  assign take       = out_valid_q && !out_stall_i;
  assign can_load_o = !out_valid_q || (take && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
      left_q      <= chans_i;
    end else if (take) begin
      out_valid_q <= !is_last;
      left_q      <= left_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign last_channel_o = is_last;

  `TOS_ASSERT_NEVER(a_left_zero, clk_i, rst_ni,
    out_valid_q && left_q == CntW'(0), "word pending with no copies left")
  `TOS_ASSERT(a_left_dec, clk_i, rst_ni,
    (take && !is_last) |=> out_valid_q && left_q == $past(left_q) - CntW'(1),
    "copy count did not step down")

endmodule

`default_nettype wire

@@ design/tone_oscillator_sine_square_unit.sv @@
// ----------------------------------------------------------------------------
// tone_oscillator_sine_square_unit
// Sine or square tone oscillator: one frame request in, one sample per
// channel out, the final copy of each frame flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (register) and
//   cfg_data_i; ready is always high. Write only while the block is idle.
//   Input: in_valid_i/in_stall_o carrying frame_tick_i. A word with the tick
//   low is taken and dropped without advancing the phase.
//   Output: out_valid_o/out_stall_i carrying sample_o and last_channel_o.
//   Pipeline: an accepted frame passes the table read, then the gain
//   multiply, then the output register, before its first sample is valid.
//   Throughput: one output word per cycle while out_stall_i is low, so a
//   frame occupies the output for one word per channel (two for stereo) and
//   the input takes frames at that pace once the two stages behind the output fill;
//   with one channel a new frame can enter every cycle.
//   Stall: out_stall_i holds the current word; the pipeline fills and then
//   in_stall_o rises. Reset clears the phase to zero, all pipeline stages
//   to empty and the registers to sine, full volume, default step, stereo.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tone_oscillator_sine_square_unit #(
  parameter int MaxChannels   = tos_pkg::MaxChannelsDef,
  parameter int SineTableBits = tos_pkg::SineTableBitsDef,
  parameter int PhaseBits     = tos_pkg::PhaseBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tos_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [tos_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            frame_tick_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [tos_pkg::SampleW-1:0]   sample_o,
  output logic                                 last_channel_o
);
  import tos_pkg::*;

  localparam int CntW = $clog2(MaxChannels + 1);

  logic                  wave_shape_q;
  logic [VolumeW-1:0]    volume_q;
  logic [PhaseStepW-1:0] phase_step_q;
  logic [ChanCfgW-1:0]   chan_cfg_q;

  logic                  in_acc, launch;
  logic [CntW-1:0]       chans;
  logic [SineTableBits-1:0] rom_addr;
  logic                  negative;
  logic [RomDataW-1:0]   rom_data;

  logic                  s1_v_q, s1_sq_q, s1_neg_q;
  logic [CntW-1:0]       s1_chans_q;
  logic                  s1_shift;

  logic                  s2_v_q;
  frame_t                s2_frame_q;
  logic [CntW-1:0]       s2_chans_q;
  logic [ValueW-1:0]     value;
  logic                  em_can_load, em_load, s2_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q <= 1'b0;
      volume_q     <= VolumeRst;
      phase_step_q <= PhaseStepRst;
      chan_cfg_q   <= ChanCfgRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WAVE_SHAPE:    wave_shape_q <= cfg_data_i[0];
        CFG_VOLUME:        volume_q     <= cfg_data_i[VolumeW-1:0];
        CFG_PHASE_STEP:    phase_step_q <= cfg_data_i[PhaseStepW-1:0];
        CFG_CHANNEL_COUNT: chan_cfg_q   <= cfg_data_i[ChanCfgW-1:0];
        default: ;
      endcase
    end
  end

  // clamp channel count into one to the channel limit
  always_comb begin
    if (chan_cfg_q == '0) begin
      chans = CntW'(1);
    end else if (int'(chan_cfg_q) > MaxChannels) begin
      chans = CntW'(MaxChannels);
    end else begin
      chans = CntW'(chan_cfg_q);
    end
  end

  assign em_load   = s2_v_q && em_can_load;
  assign s2_free   = !s2_v_q || em_load;
  assign s1_shift  = s1_v_q && s2_free;
  assign in_stall_o = s1_v_q && !s2_free;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign launch    = in_acc && frame_tick_i;

  tos_phase_acc #(
    .PhaseBits (PhaseBits),
    .TableBits (SineTableBits)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (launch),
    .phase_step_i (phase_step_q),
    .rom_addr_o   (rom_addr),
    .negative_o   (negative)
  );

  tos_sine_rom #(
    .TableBits (SineTableBits)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (launch),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (launch) begin
        s1_v_q <= 1'b1;
      end else if (s1_shift) begin
        s1_v_q <= 1'b0;
      end
      if (s1_shift) begin
        s2_v_q <= 1'b1;
      end else if (em_load) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      s1_sq_q    <= wave_shape_q;
      s1_neg_q   <= negative;
      s1_chans_q <= chans;
    end
  end

  assign value = s1_sq_q ? SquareValue : ValueW'(rom_data);

  always_ff @(posedge clk_i) begin
    if (s1_shift) begin
      s2_frame_q.prod     <= ProdW'(volume_q) * ProdW'(value);
      s2_frame_q.negative <= s1_neg_q;
      s2_chans_q          <= s1_chans_q;
    end
  end

  tos_frame_out #(
    .MaxChannels (MaxChannels)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (em_load),
    .frame_i        (s2_frame_q),
    .chans_i        (s2_chans_q),
    .can_load_o     (em_can_load),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sample_o       (sample_o),
    .last_channel_o (last_channel_o)
  );

  `TOS_ASSERT(a_launch, clk_i, rst_ni,
    launch |=> s1_v_q, "accepted frame lost at the table stage")
  `TOS_ASSERT(a_no_stall_empty, clk_i, rst_ni,
    !s1_v_q |-> !in_stall_o, "input stalled with an empty pipeline")

endmodule

`default_nettype wire
